// ===== hw/rtl/bmft_pkg.sv =====
// Shared types and constants for the block-mapped flash translation block.
// No dependencies; imported by the controller, datapath and top level.
package bmft_pkg;

    localparam int CMD_W    = 3;
    localparam int PAGE_W   = 12;
    localparam int PBLK_W   = 7;

    // geometry, fixed by the output field widths
    localparam int BLOCK_PAGES     = 32;
    localparam int LOGICAL_BLOCKS  = 64;
    localparam int PHYSICAL_BLOCKS = 72;

    localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PROGRAM   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COPY      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NOT_FOUND = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NO_FREE   = 3'd5;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request
        logic map_rd;      // read map entry of current lbn
        logic pop;         // pop free stack (new map or merge block)
        logic pop_merge;   // pop is for the merge destination
        logic scan_init;   // start page scan from the top
        logic spare_rd;    // issue spare read of scan page
        logic scan_step;   // evaluate returned spare entry, advance
        logic merge_fin;   // erase done: push old block, remap
        logic prog;        // program host page and bump fill
        logic emit;        // load output register from cmd fields
        logic [CMD_W-1:0] emit_cmd;
        logic emit_last;
    } bmft_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;    // output register holds an unread beat
        logic out_range;   // lbn beyond logical range
        logic is_write;
        logic mapped;
        logic full;
        logic fill_zero;
        logic free_empty;
        logic scan_done;   // scan index is at the bottom page
        logic hit;         // read: spare matches; merge: copy needed
    } bmft_sts_t;

endpackage

// ===== hw/rtl/bmft_ctrl.sv =====
// Controller state machine of the flash translation block.
// Depends on bmft_pkg; drives bmft_dp through command/status structs.
module bmft_ctrl
    import bmft_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_fire,
    output logic      s_ready,
    input  bmft_sts_t sts,
    output bmft_ctl_t ctl
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MAP    = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_SRD    = 4'd3;
    localparam logic [3:0] ST_SCHK   = 4'd4;
    localparam logic [3:0] ST_MRD    = 4'd5;
    localparam logic [3:0] ST_MCHK   = 4'd6;
    localparam logic [3:0] ST_ERASE  = 4'd7;
    localparam logic [3:0] ST_PROG   = 4'd8;
    localparam logic [3:0] ST_FLUSH  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ctl.load   = 1'b1;
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                ctl.map_rd = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!sts.out_busy) begin
                    if (sts.out_range) begin
                        ctl.emit = 1'b1; ctl.emit_cmd = CMD_NOT_FOUND; ctl.emit_last = 1'b1;
                        state_next = ST_FLUSH;
                    end else if (!sts.is_write) begin
                        if (!sts.mapped || sts.fill_zero) begin
                            ctl.emit = 1'b1; ctl.emit_cmd = CMD_NOT_FOUND;
                            ctl.emit_last = 1'b1;
                            state_next = ST_FLUSH;
                        end else begin
                            ctl.scan_init = 1'b1;
                            state_next    = ST_SRD;
                        end
                    end else if (!sts.mapped) begin
                        if (sts.free_empty) begin
                            ctl.emit = 1'b1; ctl.emit_cmd = CMD_NO_FREE;
                            ctl.emit_last = 1'b1;
                            state_next = ST_FLUSH;
                        end else begin
                            ctl.pop    = 1'b1;
                            state_next = ST_PROG;
                        end
                    end else if (sts.full) begin
                        if (sts.free_empty) begin
                            ctl.emit = 1'b1; ctl.emit_cmd = CMD_NO_FREE;
                            ctl.emit_last = 1'b1;
                            state_next = ST_FLUSH;
                        end else begin
                            ctl.pop       = 1'b1;
                            ctl.pop_merge = 1'b1;
                            ctl.scan_init = 1'b1;
                            state_next    = ST_MRD;
                        end
                    end else begin
                        state_next = ST_PROG;
                    end
                end
            end
            ST_SRD: begin
                ctl.spare_rd = 1'b1;
                state_next   = ST_SCHK;
            end
            ST_SCHK: begin
                if (!sts.out_busy) begin
                    if (sts.hit) begin
                        ctl.emit = 1'b1; ctl.emit_cmd = CMD_READ; ctl.emit_last = 1'b1;
                        state_next = ST_FLUSH;
                    end else begin
                        ctl.scan_step = 1'b1;
                        if (sts.scan_done) begin
                            ctl.emit = 1'b1; ctl.emit_cmd = CMD_NOT_FOUND;
                            ctl.emit_last = 1'b1;
                            state_next = ST_FLUSH;
                        end else begin
                            state_next = ST_SRD;
                        end
                    end
                end
            end
            ST_MRD: begin
                ctl.spare_rd = 1'b1;
                state_next   = ST_MCHK;
            end
            ST_MCHK: begin
                if (!sts.out_busy) begin
                    ctl.scan_step = 1'b1;
                    if (sts.hit) begin
                        ctl.emit = 1'b1; ctl.emit_cmd = CMD_COPY;
                    end
                    state_next = sts.scan_done ? ST_ERASE : ST_MRD;
                end
            end
            ST_ERASE: begin
                if (!sts.out_busy) begin
                    ctl.emit = 1'b1; ctl.emit_cmd = CMD_ERASE;
                    ctl.merge_fin = 1'b1;
                    state_next = ST_PROG;
                end
            end
            ST_PROG: begin
                if (!sts.out_busy) begin
                    ctl.prog = 1'b1;
                    ctl.emit = 1'b1; ctl.emit_cmd = CMD_PROGRAM; ctl.emit_last = 1'b1;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!sts.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/bmft_dp.sv =====
// Datapath of the flash translation block: map, free stack, spare mirror,
// scan counters and the output register. Depends on bmft_pkg.
module bmft_dp
    import bmft_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  bmft_ctl_t         ctl,
    output bmft_sts_t         sts,
    input  logic              in_action,
    input  logic [10:0]       in_sector,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CMD_W-1:0]  out_command,
    output logic [PAGE_W-1:0] out_target,
    output logic [PAGE_W-1:0] out_source,
    output logic [PBLK_W-1:0] out_erased,
    output logic              out_last
);

    localparam int OFF_W = $clog2(BLOCK_PAGES);
    localparam int FILL_W = $clog2(BLOCK_PAGES + 1);
    localparam int LB_W = (LOGICAL_BLOCKS > 1) ? $clog2(LOGICAL_BLOCKS) : 1;
    localparam int PB_W = $clog2(PHYSICAL_BLOCKS);
    localparam int FC_W = $clog2(PHYSICAL_BLOCKS + 1);
    localparam int NPAGES = PHYSICAL_BLOCKS * BLOCK_PAGES;
    localparam int PG_W = $clog2(NPAGES);

    // request
    logic              act_reg;
    logic [10:0]       sector_reg;
    logic [10:0]       lbn_full;
    logic [OFF_W-1:0]  off;
    logic [LB_W-1:0]   lbn;
    logic              range_ok;

    assign lbn_full = sector_reg / 11'(BLOCK_PAGES);
    assign off      = OFF_W'(sector_reg % 11'(BLOCK_PAGES));
    assign range_ok = ({21'd0, lbn_full} < 32'(LOGICAL_BLOCKS));
    assign lbn      = LB_W'(lbn_full);

    // map
    logic [LOGICAL_BLOCKS-1:0] mvalid_reg;
    logic [PB_W-1:0]   mpb_mem [LOGICAL_BLOCKS];
    logic [FILL_W-1:0] mfill_mem [LOGICAL_BLOCKS];
    logic [PB_W-1:0]   pbn_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              mapped_reg;

    // free stack: reset contents are PHYSICAL_BLOCKS-1-k, tracked by a
    // per-entry written bit; top entry is read during the map lookup
    logic [PB_W-1:0]   fs_mem [PHYSICAL_BLOCKS];
    logic [PHYSICAL_BLOCKS-1:0] fs_wr_reg;
    logic [FC_W-1:0]   fcount_reg;
    logic [PB_W-1:0]   fs_top_idx;
    logic [PB_W-1:0]   fs_top_reg;
    logic [PB_W-1:0]   nb_reg;

    assign fs_top_idx = (fcount_reg == '0) ? '0 : PB_W'(fcount_reg - FC_W'(1));

    // spare mirror
    logic [OFF_W-1:0]  spare_mem [NPAGES];
    logic [OFF_W-1:0]  spare_q_reg;
    logic [OFF_W-1:0]  sidx_reg;
    logic              sdone_reg;
    logic [FILL_W-1:0] k_reg;
    logic [BLOCK_PAGES-1:0] copied_reg;
    logic [PG_W-1:0]   src_page;
    logic [PG_W-1:0]   dst_page;
    logic [PG_W-1:0]   prog_page;
    logic [PB_W-1:0]   prog_blk;
    logic [FILL_W-1:0] prog_fill;
    logic              merge_hit;

    assign src_page = PG_W'(pbn_reg) * PG_W'(BLOCK_PAGES) + PG_W'(sidx_reg);
    assign dst_page = PG_W'(nb_reg) * PG_W'(BLOCK_PAGES) + PG_W'(k_reg);
    assign merge_hit = !copied_reg[spare_q_reg] && (k_reg < FILL_W'(BLOCK_PAGES));
    assign prog_blk  = pbn_reg;
    assign prog_fill = fill_reg;
    assign prog_page = PG_W'(prog_blk) * PG_W'(BLOCK_PAGES) + PG_W'(prog_fill);

    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            act_reg    <= in_action;
            sector_reg <= in_sector;
        end
        if (ctl.map_rd) begin
            pbn_reg    <= mpb_mem[lbn];
            fill_reg   <= mvalid_reg[lbn] ? mfill_mem[lbn] : '0;
            mapped_reg <= mvalid_reg[lbn];
            fs_top_reg <= fs_wr_reg[fs_top_idx] ? fs_mem[fs_top_idx]
                        : PB_W'(PHYSICAL_BLOCKS - 1) - fs_top_idx;
        end
        if (ctl.spare_rd) begin
            spare_q_reg <= spare_mem[src_page];
        end
        if (ctl.scan_init) begin
            sidx_reg  <= ctl.pop_merge ? OFF_W'(BLOCK_PAGES - 1)
                                       : OFF_W'(fill_reg - FILL_W'(1));
            sdone_reg <= ctl.pop_merge ? 1'b0 : (fill_reg == FILL_W'(1));
            k_reg     <= '0;
            copied_reg <= BLOCK_PAGES'(1) << off;
        end
        if (ctl.scan_step) begin
            sidx_reg  <= sidx_reg - OFF_W'(1);
            sdone_reg <= (sidx_reg == OFF_W'(1));
            copied_reg[spare_q_reg] <= 1'b1;
            if (act_reg == ACT_WRITE && merge_hit) begin
                spare_mem[dst_page] <= spare_q_reg;
                k_reg <= k_reg + FILL_W'(1);
            end
        end
        if (ctl.pop) begin
            if (ctl.pop_merge) begin
                nb_reg <= fs_top_reg;
            end else begin
                pbn_reg    <= fs_top_reg;
                mpb_mem[lbn] <= fs_top_reg;
                fill_reg   <= '0;
                mapped_reg <= 1'b1;
            end
        end
        if (ctl.merge_fin) begin
            if (fcount_reg < FC_W'(PHYSICAL_BLOCKS)) begin
                fs_mem[PB_W'(fcount_reg)] <= pbn_reg;
            end
            mpb_mem[lbn] <= nb_reg;
            pbn_reg      <= nb_reg;
            fill_reg     <= k_reg;
        end
        if (ctl.prog) begin
            spare_mem[prog_page] <= off;
            mfill_mem[lbn]       <= fill_reg + FILL_W'(1);
        end
        if (ctl.emit) begin
            out_command <= ctl.emit_cmd;
            out_last    <= ctl.emit_last;
            unique case (ctl.emit_cmd)
                CMD_READ: begin
                    out_target <= PAGE_W'(src_page);
                    out_source <= '0;
                    out_erased <= '0;
                end
                CMD_PROGRAM: begin
                    out_target <= PAGE_W'(prog_page);
                    out_source <= '0;
                    out_erased <= '0;
                end
                CMD_COPY: begin
                    out_target <= PAGE_W'(dst_page);
                    out_source <= PAGE_W'(src_page);
                    out_erased <= '0;
                end
                CMD_ERASE: begin
                    out_target <= '0;
                    out_source <= '0;
                    out_erased <= PBLK_W'(pbn_reg);
                end
                default: begin
                    out_target <= '0;
                    out_source <= '0;
                    out_erased <= '0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg    <= '0;
            fs_wr_reg     <= '0;
            fcount_reg    <= FC_W'(PHYSICAL_BLOCKS);
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.pop) begin
                fcount_reg <= fcount_reg - FC_W'(1);
                if (!ctl.pop_merge) begin
                    mvalid_reg[lbn] <= 1'b1;
                end
            end
            if (ctl.merge_fin && fcount_reg < FC_W'(PHYSICAL_BLOCKS)) begin
                fs_wr_reg[PB_W'(fcount_reg)] <= 1'b1;
                fcount_reg <= fcount_reg + FC_W'(1);
            end
            if (ctl.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    always_comb begin
        sts.out_busy   = out_valid_reg && !out_ready;
        sts.out_range  = !range_ok;
        sts.is_write   = (act_reg == ACT_WRITE);
        sts.mapped     = mapped_reg;
        sts.full       = (fill_reg >= FILL_W'(BLOCK_PAGES));
        sts.fill_zero  = (fill_reg == '0);
        sts.free_empty = (fcount_reg == '0);
        sts.scan_done  = sdone_reg;
        sts.hit        = (act_reg == ACT_WRITE) ? merge_hit : (spare_q_reg == off);
    end

endmodule

// ===== hw/rtl/block_mapping_flash_translation.sv =====
// Block-mapped flash translation command generator: top level.
// Depends on bmft_pkg, bmft_ctrl and bmft_dp.
//
// One request beat (read or write of a logical sector) is taken at a time;
// s_tready stays low until its last command beat has left the output
// register. A read walks the mapped block newest to oldest, one page per
// spare-mirror read and compare. A write to a non-full block goes straight
// to programming; a write to a full block runs a merge that walks all
// BLOCK_PAGES pages and emits up to BLOCK_PAGES+1 command beats. Output
// stalls hold the walk.
module block_mapping_flash_translation
    import bmft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] action, [11:1] sector_number
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] command, [14:3] target_page, [26:15] source_page, [33:27] erased_block
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    bmft_ctl_t ctl;
    bmft_sts_t sts;
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] tgt;
    logic [PAGE_W-1:0] src;
    logic [PBLK_W-1:0] blk;

    bmft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_tvalid && s_tready),
        .s_ready (s_tready),
        .sts     (sts),
        .ctl     (ctl)
    );

    bmft_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .in_action   (s_tdata[0]),
        .in_sector   (s_tdata[11:1]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_command (cmd),
        .out_target  (tgt),
        .out_source  (src),
        .out_erased  (blk),
        .out_last    (m_tlast)
    );

    assign m_tdata = {6'd0, blk, src, tgt, cmd};

endmodule

// ===== test/bmft_checker.sv =====
// Scoreboard for the flash translation block: watches both stream channels,
// predicts command beats from accepted requests and compares them.
// Depends on bmft_pkg.
module bmft_checker
    import bmft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PPB  = BLOCK_PAGES;
    localparam int LBLK = LOGICAL_BLOCKS;
    localparam int PBLK = PHYSICAL_BLOCKS;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] tgt;
        logic [PAGE_W-1:0] src;
        logic [PBLK_W-1:0] blk;
        logic              last;
    } flash_cmd_t;

    flash_cmd_t cmd_q[$];

    bit              lmap_ok[LBLK];
    logic [6:0]      lmap_pb[LBLK];
    int              lmap_fill[LBLK];
    logic [6:0]      free_blk[PBLK];
    int              free_n;
    logic [4:0]      spare_off[PBLK*PPB];
    bit              seen_off[PPB];

    assign pending = cmd_q.size();

    function automatic int page_addr(int b, int i);
        return b * PPB + i;
    endfunction

    task automatic push_cmd(logic [2:0] c, int t, int s, int b, int l);
        flash_cmd_t e;
        e.cmd = c;
        e.tgt = PAGE_W'(t);
        e.src = PAGE_W'(s);
        e.blk = PBLK_W'(b);
        e.last = 1'(l);
        cmd_q.push_back(e);
    endtask

    task automatic translate_request(logic act, logic [10:0] sec);
        int lbn, off, pb, fill, nb, k, pg, o;
        bit found;
        lbn = int'(sec) / PPB;
        off = int'(sec) % PPB;
        found = 0;
        if (lbn >= LBLK) begin
            push_cmd(CMD_NOT_FOUND, 0, 0, 0, 1);
            return;
        end
        if (act == ACT_READ) begin
            if (lmap_ok[lbn]) begin
                pb = int'(lmap_pb[lbn]);
                for (int i = lmap_fill[lbn]; i > 0 && !found; i--) begin
                    pg = page_addr(pb, i - 1);
                    if (int'(spare_off[pg]) == off) begin
                        push_cmd(CMD_READ, pg, 0, 0, 1);
                        found = 1;
                    end
                end
            end
            if (!found) push_cmd(CMD_NOT_FOUND, 0, 0, 0, 1);
            return;
        end
        if (!lmap_ok[lbn]) begin
            if (free_n == 0) begin
                push_cmd(CMD_NO_FREE, 0, 0, 0, 1);
                return;
            end
            free_n--;
            lmap_pb[lbn] = free_blk[free_n];
            lmap_ok[lbn] = 1;
            lmap_fill[lbn] = 0;
        end
        pb = int'(lmap_pb[lbn]);
        fill = lmap_fill[lbn];
        if (fill >= PPB) begin
            if (free_n == 0) begin
                push_cmd(CMD_NO_FREE, 0, 0, 0, 1);
                return;
            end
            free_n--;
            nb = int'(free_blk[free_n]);
            k = 0;
            foreach (seen_off[j]) seen_off[j] = 0;
            seen_off[off] = 1;
            for (int i = PPB; i > 0; i--) begin
                o = int'(spare_off[page_addr(pb, i - 1)]);
                if (!seen_off[o] && k < PPB) begin
                    spare_off[page_addr(nb, k)] = 5'(o);
                    push_cmd(CMD_COPY, page_addr(nb, k), page_addr(pb, i - 1), 0, 0);
                    k++;
                end
                seen_off[o] = 1;
            end
            push_cmd(CMD_ERASE, 0, 0, pb, 0);
            if (free_n < PBLK) begin
                free_blk[free_n] = 7'(pb);
                free_n++;
            end
            lmap_pb[lbn] = 7'(nb);
            pb = nb;
            fill = k;
        end
        pg = page_addr(pb, fill);
        spare_off[pg] = 5'(off);
        lmap_fill[lbn] = fill + 1;
        push_cmd(CMD_PROGRAM, pg, 0, 0, 1);
    endtask

    initial begin
        fail_count = 0;
        foreach (lmap_ok[i]) begin
            lmap_ok[i] = 0; lmap_pb[i] = '0; lmap_fill[i] = 0;
        end
        foreach (free_blk[k]) free_blk[k] = 7'(PBLK - 1 - k);
        free_n = PBLK;
        foreach (spare_off[i]) spare_off[i] = '0;
    end

    always @(posedge aclk) begin
        flash_cmd_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready) translate_request(s_tdata[0], s_tdata[11:1]);
            if (m_tvalid && m_tready) begin
                got.cmd = m_tdata[2:0];
                got.tgt = m_tdata[14:3];
                got.src = m_tdata[26:15];
                got.blk = m_tdata[33:27];
                got.last = m_tlast;
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, got);
                    fail_count++;
                end else begin
                    want = cmd_q.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch expected cmd=%0d tgt=%0d src=%0d ",
                                  "blk=%0d last=%0b actual cmd=%0d tgt=%0d src=%0d ",
                                  "blk=%0d last=%0b"},
                                 $time, want.cmd, want.tgt, want.src, want.blk,
                                 want.last, got.cmd, got.tgt, got.src, got.blk,
                                 got.last);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== test/block_mapping_flash_translation_test.sv =====
// Top of the flash translation testbench: clock, reset, request stimulus,
// output back-pressure and verdict. Depends on bmft_pkg, the block and bmft_checker.
module block_mapping_flash_translation_test;
    import bmft_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count, pending;
    bit          quiet = 0;
    bit          hold_long = 0;

    always #5 aclk = ~aclk;

    block_mapping_flash_translation dut (.*);
    bmft_checker chk (.*);

    // valid stays up between back-to-back requests; it drops only for a gap
    task automatic send_req(logic act, logic [10:0] sec);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, sec, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_tready <= 0;
                repeat (300) @(negedge aclk);
                hold_long = 0;
            end
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int lb, r, hot;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: reads of unmapped, extremes, fill to merge
        send_req(ACT_READ, 11'd0);
        send_req(ACT_READ, 11'd2047);
        send_req(ACT_WRITE, 11'd2047);
        send_req(ACT_WRITE, 11'd0);
        send_req(ACT_READ, 11'd0);
        send_req(ACT_READ, 11'd1);
        send_req(ACT_WRITE, 11'd2047 >> 1);
        send_req(ACT_READ, 11'd1023);
        for (int i = 0; i < 17; i++) send_req(ACT_WRITE, 11'(i % 5));
        hold_long = 1;
        for (int i = 0; i < 20; i++) send_req(ACT_WRITE, 11'(i % 3));
        send_req(ACT_READ, 11'd4);
        // random: hot blocks to force merges, with some noise
        hot = $urandom_range(0, 63);
        for (int i = 0; i < 310; i++) begin
            if (i > 260) quiet = 1;
            r = $urandom_range(0, 9);
            if (r < 1) send_req(1'($urandom_range(0, 1)), 11'($urandom));
            else begin
                lb = (r < 6) ? hot : $urandom_range(0, 63);
                if ($urandom_range(0, 20) == 0) hot = $urandom_range(0, 63);
                send_req($urandom_range(0, 2) != 0, 11'(lb * 32 + $urandom_range(0, 31)));
            end
        end
        // map every logical block
        for (int b = 0; b < 64; b++) send_req(ACT_WRITE, 11'(b * 32 + 31));
        for (int i = 0; i < 40; i++) send_req(ACT_WRITE, 11'(hot * 32 + (i % 2)));
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/bmft_pkg.sv
hw/rtl/bmft_ctrl.sv
hw/rtl/bmft_dp.sv
hw/rtl/block_mapping_flash_translation.sv
test/bmft_checker.sv
test/block_mapping_flash_translation_test.sv
